[hw/rtl/fpm_pkg.sv]
// ----------------------------------------------------------------------------
// fpm_pkg: floating-point multiplier package
// format constants and the decoded operand type shared by the datapath
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int unsigned ExpBits  = 8;
  localparam int unsigned FracBits = 23;
  localparam int unsigned WordBits = 1 + ExpBits + FracBits;
  localparam int unsigned ManBits  = FracBits + 1;
  localparam int unsigned ProdBits = 2 * ManBits;
  localparam int unsigned ExpWBits = ExpBits + 2;

  localparam logic [ExpBits-1:0]  ExpMax  = '1;
  localparam logic [ExpWBits-1:0] ExpBias = ExpWBits'((1 << (ExpBits - 1)) - 1);

  typedef struct packed {
    logic                sign;
    logic                nan;
    logic                inf;
    logic                zero;
    logic [ExpBits-1:0]  exp_a;
    logic [ExpBits-1:0]  exp_b;
    logic [ProdBits-1:0] prod;
  } stage_t;

endpackage

[hw/rtl/fpm_mul.sv]
// ----------------------------------------------------------------------------
// fpm_mul: operand decode and significand product
// classifies the operands and forms the exact significand product
// ----------------------------------------------------------------------------
module fpm_mul (
  input  logic [fpm_pkg::WordBits-1:0] operand_a_i,
  input  logic [fpm_pkg::WordBits-1:0] operand_b_i,
  output fpm_pkg::stage_t              stage_o
);

  logic [fpm_pkg::ExpBits-1:0]  ea, eb;
  logic [fpm_pkg::FracBits-1:0] fa, fb;
  logic                         inf_a, inf_b, zero_a, zero_b, nan_a, nan_b;

  always_comb begin
    ea     = operand_a_i[fpm_pkg::WordBits-2 -: fpm_pkg::ExpBits];
    eb     = operand_b_i[fpm_pkg::WordBits-2 -: fpm_pkg::ExpBits];
    fa     = operand_a_i[fpm_pkg::FracBits-1:0];
    fb     = operand_b_i[fpm_pkg::FracBits-1:0];
    nan_a  = (ea == fpm_pkg::ExpMax) && (fa != '0);
    nan_b  = (eb == fpm_pkg::ExpMax) && (fb != '0);
    inf_a  = (ea == fpm_pkg::ExpMax) && (fa == '0);
    inf_b  = (eb == fpm_pkg::ExpMax) && (fb == '0);
    zero_a = (ea == '0);
    zero_b = (eb == '0);
    stage_o.sign  = operand_a_i[fpm_pkg::WordBits-1] ^ operand_b_i[fpm_pkg::WordBits-1];
    stage_o.nan   = nan_a | nan_b | (zero_a & inf_b) | (inf_a & zero_b);
    stage_o.inf   = inf_a | inf_b;
    stage_o.zero  = zero_a | zero_b;
    stage_o.exp_a = ea;
    stage_o.exp_b = eb;
    stage_o.prod  = fpm_pkg::ProdBits'({1'b1, fa}) * fpm_pkg::ProdBits'({1'b1, fb});
  end

endmodule

[hw/rtl/fpm_round.sv]
// ----------------------------------------------------------------------------
// fpm_round: normalize, round and pack
// rounds the product to nearest even and applies special-case results
// ----------------------------------------------------------------------------
module fpm_round (
  input  fpm_pkg::stage_t              stage_i,
  output logic [fpm_pkg::WordBits-1:0] product_o
);

  localparam int unsigned F = fpm_pkg::FracBits;

  logic [fpm_pkg::ProdBits-1:0] p;
  logic                         top;
  logic [F+1:0]                 m;
  logic                         rnd, stk;
  logic [fpm_pkg::ExpWBits-1:0] e;

  always_comb begin
    top = stage_i.prod[2*F+1];
    p   = top ? stage_i.prod : {stage_i.prod[fpm_pkg::ProdBits-2:0], 1'b0};
    m   = {1'b0, p[2*F+1 -: F+1]};
    rnd = p[F];
    stk = (p[F-1:0] != '0);
    e   = fpm_pkg::ExpWBits'(stage_i.exp_a) + fpm_pkg::ExpWBits'(stage_i.exp_b)
          - fpm_pkg::ExpBias + fpm_pkg::ExpWBits'(top);
    if (rnd && (stk || m[0])) m = m + 1'b1;
    if (m[F+1]) begin
      m = m >> 1;
      e = e + 1'b1;
    end
    if (stage_i.nan) begin
      product_o = {stage_i.sign, fpm_pkg::ExpMax, {F{1'b1}}};
    end else if (stage_i.inf) begin
      product_o = {stage_i.sign, fpm_pkg::ExpMax, {F{1'b0}}};
    end else if (stage_i.zero || e[fpm_pkg::ExpWBits-1] || e == '0) begin
      product_o = {stage_i.sign, {(fpm_pkg::WordBits-1){1'b0}}};
    end else if (e >= fpm_pkg::ExpWBits'(fpm_pkg::ExpMax)) begin
      product_o = {stage_i.sign, fpm_pkg::ExpMax, {F{1'b0}}};
    end else begin
      product_o = {stage_i.sign, e[fpm_pkg::ExpBits-1:0], m[F-1:0]};
    end
  end

endmodule

[hw/rtl/fp32_multiply_ftz.sv]
// ----------------------------------------------------------------------------
// fp32_multiply_ftz: binary32 multiplier, flush to zero
// Returns the round-to-nearest-even product: the significand multiply sits
// after the input register, rounding after the product register. Subnormals
// in or out count as zero; overflow gives infinity; invalid cases give a NaN
// with an all-ones fraction. The pipeline advances, taking one operand pair
// per cycle, whenever the result register is empty or taken.
// ----------------------------------------------------------------------------
module fp32_multiply_ftz (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [fpm_pkg::WordBits-1:0] operand_a_i,
  input  logic [fpm_pkg::WordBits-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [fpm_pkg::WordBits-1:0] product_o
);

  logic                         a_valid_q, r_valid_q, adv;
  logic [fpm_pkg::WordBits-1:0] a_q, b_q, product_d, product_q;
  fpm_pkg::stage_t              stage_d, stage_q;
  logic                         s_valid_q;

  assign adv        = !r_valid_q || out_ready_i;
  assign in_ready_o = adv;

  fpm_mul u_mul (.operand_a_i(a_q), .operand_b_i(b_q), .stage_o(stage_d));
  fpm_round u_round (.stage_i(stage_q), .product_o(product_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      s_valid_q <= a_valid_q;
      r_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= operand_a_i;
      b_q       <= operand_b_i;
      stage_q   <= stage_d;
      product_q <= product_d;
    end
  end

  assign out_valid_o = r_valid_q;
  assign product_o   = product_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(product_o))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> a_valid_q)
    else $error("transfer lost");

endmodule
